// ----- rtl/core/bpsm_pkg.sv -----
// bpsm_pkg: shared types and constants for the battery power state monitor
// no dependencies; imported by the monitor top level and its checker

package bpsm_pkg;

	// power state codes as shown on the result channel
	typedef enum logic [1:0] {
		ST_BATTERY   = 2'd0,
		ST_CHARGING  = 2'd1,
		ST_CHARGED   = 2'd2,
		ST_LOW_POWER = 2'd3
	} power_state_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_THR_FLYING = 2'd0,
		CFG_THR_STATIC = 2'd1,
		CFG_TIMEOUT    = 2'd2
	} cfg_index_t;

	// item kinds
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	// charger flag bit positions
	localparam int FLAG_PGOOD_BIT = 0;
	localparam int FLAG_CHG_BIT   = 1;

	// shortest report that is taken
	localparam logic [7:0] MIN_REPORT_BYTES = 8'd5;

	// reset values
	localparam logic [15:0] VOLTAGE_RESET_MV    = 16'd3700;
	localparam logic [15:0] THR_FLYING_RESET_MV = 16'd3200;
	localparam logic [15:0] THR_STATIC_RESET_MV = 16'd3000;
	localparam logic [15:0] TIMEOUT_RESET_MS    = 16'd5000;

endpackage

// ----- rtl/core/battery_power_state_monitor.sv -----
// battery_power_state_monitor: battery report / tick processing with one status per item
// depends on bpsm_pkg (power state codes, register indexes, constants)
//
// channel   direction  handshake                 payload
// in        sink       in_valid / in_ready       kind, report_bytes, voltage_mv,
//                                                charger_flags, flying, now_ms
// out       source     out_valid / out_ready     voltage_now_mv .. monitor_ok
// cfg       sink       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// an item is registered at accept, evaluated combinationally against current state and
// lands in the result register; one item per cycle sustained while out is not stalled.
// the stage register and the result register each hold one item; a stall on out
// backs up into in_ready only once both are full.
// reset clears state to 3700 mV, no peak/floor, no stamp, battery, no flags.
// cfg_ready is always high; writes take effect at once.

module battery_power_state_monitor import bpsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  report_bytes,
	input  logic [15:0] voltage_mv,
	input  logic [1:0]  charger_flags,
	input  logic        flying,
	input  logic [31:0] now_ms,
	// result item channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] voltage_now_mv,
	output logic [15:0] voltage_peak_mv,
	output logic [15:0] voltage_floor_mv,
	output logic [1:0]  power_state,
	output logic        is_low_power,
	output logic        is_charging,
	output logic        monitor_ok,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [15:0] thr_flying_q, thr_static_q, timeout_q;

	// monitor state
	logic [15:0]  voltage_q, peak_q, floor_q;
	logic [31:0]  low_since_q;
	power_state_t state_q;
	logic [1:0]   flags_q;

	// stage register
	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  bytes_s1;
	logic [15:0] volt_s1;
	logic [1:0]  flags_s1;
	logic        flying_s1;
	logic [31:0] now_s1;

	// result register
	logic         out_valid_q;
	logic [15:0]  res_now_q, res_peak_q, res_floor_q;
	power_state_t res_state_q;

	// next state
	logic [15:0]  voltage_nx, peak_nx, floor_nx, thr;
	logic [31:0]  low_since_nx, elapsed;
	power_state_t state_nx, state_mid;
	logic [1:0]   flags_nx;
	logic         advance, take_report;

	// pipeline flow
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_flying_q <= THR_FLYING_RESET_MV;
			thr_static_q <= THR_STATIC_RESET_MV;
			timeout_q    <= TIMEOUT_RESET_MS;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_THR_FLYING: thr_flying_q <= cfg_data;
				CFG_THR_STATIC: thr_static_q <= cfg_data;
				CFG_TIMEOUT:    timeout_q    <= cfg_data;
				default:        ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1   <= kind;
			bytes_s1  <= report_bytes;
			volt_s1   <= voltage_mv;
			flags_s1  <= charger_flags;
			flying_s1 <= flying;
			now_s1    <= now_ms;
		end
	end

	// item evaluation against current state
	always_comb begin
		voltage_nx   = voltage_q;
		peak_nx      = peak_q;
		floor_nx     = floor_q;
		low_since_nx = low_since_q;
		state_nx     = state_q;
		flags_nx     = flags_q;
		state_mid    = state_q;
		thr          = flying_s1 ? thr_flying_q : thr_static_q;
		elapsed      = now_s1 - low_since_q;
		take_report  = (kind_s1 == KIND_REPORT) && (bytes_s1 >= MIN_REPORT_BYTES);

		if (take_report) begin
			flags_nx = flags_s1;
			if (volt_s1 != 16'd0) begin
				voltage_nx = volt_s1;
				if (volt_s1 > peak_q)
					peak_nx = volt_s1;
				if (floor_q == 16'd0 || volt_s1 < floor_q)
					floor_nx = volt_s1;
			end
		end else if (kind_s1 == KIND_TICK) begin
			// low voltage timing; a zero stamp means none taken
			if (voltage_q < thr) begin
				if (low_since_q == 32'd0)
					low_since_nx = now_s1;
				else if (elapsed > {16'd0, timeout_q})
					state_mid = ST_LOW_POWER;
			end else begin
				low_since_nx = 32'd0;
				if (state_q == ST_LOW_POWER)
					state_mid = ST_BATTERY;
			end
			// charger flags override, low power survives without power good
			if (flags_q[FLAG_PGOOD_BIT] && !flags_q[FLAG_CHG_BIT])
				state_nx = ST_CHARGED;
			else if (flags_q[FLAG_PGOOD_BIT])
				state_nx = ST_CHARGING;
			else if (state_mid != ST_LOW_POWER)
				state_nx = ST_BATTERY;
			else
				state_nx = ST_LOW_POWER;
		end
	end

	// monitor state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_q   <= VOLTAGE_RESET_MV;
			peak_q      <= 16'd0;
			floor_q     <= 16'd0;
			low_since_q <= 32'd0;
			state_q     <= ST_BATTERY;
			flags_q     <= 2'd0;
		end else if (advance) begin
			voltage_q   <= voltage_nx;
			peak_q      <= peak_nx;
			floor_q     <= floor_nx;
			low_since_q <= low_since_nx;
			state_q     <= state_nx;
			flags_q     <= flags_nx;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_now_q   <= voltage_nx;
			res_peak_q  <= peak_nx;
			res_floor_q <= floor_nx;
			res_state_q <= state_nx;
		end
	end

	// result ports
	assign out_valid        = out_valid_q;
	assign voltage_now_mv   = res_now_q;
	assign voltage_peak_mv  = res_peak_q;
	assign voltage_floor_mv = res_floor_q;
	assign power_state      = res_state_q;
	assign is_low_power     = (res_state_q == ST_LOW_POWER);
	assign is_charging      = (res_state_q == ST_CHARGING);
	assign monitor_ok       = (res_now_q != 16'd0);

endmodule

// ----- rtl/core/bpsm_checker.sv -----
// bpsm_checker: port-level assertions for battery_power_state_monitor
// depends on bpsm_pkg; bound to the top level at the end of this file

module bpsm_checker import bpsm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] voltage_now_mv,
	input logic [15:0] voltage_peak_mv,
	input logic [15:0] voltage_floor_mv,
	input logic [1:0]  power_state,
	input logic        is_low_power,
	input logic        is_charging,
	input logic        monitor_ok
);

	// a stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(voltage_now_mv)
			&& $stable(power_state) && $stable(voltage_floor_mv))
		else $error("result item changed while stalled");

	// status flags agree with the power state
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_low_power == (power_state == ST_LOW_POWER))
			&& (is_charging == (power_state == ST_CHARGING)))
		else $error("status flags disagree with power state");

	// the stored voltage is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> monitor_ok && voltage_now_mv != 16'd0)
		else $error("stored voltage reads zero");

	// once a floor is set, current voltage lies between floor and peak
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && voltage_floor_mv != 16'd0 |->
			voltage_floor_mv <= voltage_now_mv && voltage_now_mv <= voltage_peak_mv)
		else $error("voltage outside floor and peak");

endmodule

bind battery_power_state_monitor bpsm_checker u_bpsm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.voltage_now_mv   (voltage_now_mv),
	.voltage_peak_mv  (voltage_peak_mv),
	.voltage_floor_mv (voltage_floor_mv),
	.power_state      (power_state),
	.is_low_power     (is_low_power),
	.is_charging      (is_charging),
	.monitor_ok       (monitor_ok)
);

// ----- bench/bpsm_status_pkg.sv -----
`timescale 1ns / 1ps
// bpsm_status_pkg: status predictor and in-order result checker for the battery monitor bench
// depends on bpsm_pkg (power state codes, register indexes, report length limit)

package bpsm_status_pkg;
	import bpsm_pkg::*;

	// one status item as seen on the result channel
	typedef struct packed {
		logic [15:0]  voltage_now_mv;
		logic [15:0]  voltage_peak_mv;
		logic [15:0]  voltage_floor_mv;
		power_state_t power_state;
		logic         is_low_power;
		logic         is_charging;
		logic         monitor_ok;
	} monitor_status_t;

	class monitor_status_board;
		// thresholds and timeout as last written
		logic [15:0] thr_flying_mv;
		logic [15:0] thr_static_mv;
		logic [15:0] timeout_ms;
		// tracked monitor state
		logic [15:0] batt_mv;
		logic [15:0] peak_mv;
		logic [15:0] floor_mv;
		logic [31:0] low_since_ms;
		power_state_t state;
		logic [1:0]  flags;
		// statuses still owed by the block, oldest first
		monitor_status_t status_q[$];
		int fail_count;

		function new();
			thr_flying_mv = THR_FLYING_RESET_MV;
			thr_static_mv = THR_STATIC_RESET_MV;
			timeout_ms    = TIMEOUT_RESET_MS;
			batt_mv       = VOLTAGE_RESET_MV;
			peak_mv       = '0;
			floor_mv      = '0;
			low_since_ms  = '0;
			state         = ST_BATTERY;
			flags         = '0;
			fail_count    = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [15:0] data);
			case (idx)
				CFG_THR_FLYING: thr_flying_mv = data;
				CFG_THR_STATIC: thr_static_mv = data;
				CFG_TIMEOUT:    timeout_ms    = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		// advance the state by one accepted item and queue the status it yields
		function void note_item(logic kind, logic [7:0] nbytes, logic [15:0] v,
			logic [1:0] fl, logic fly, logic [31:0] now);
			logic [15:0] thr;
			logic [31:0] elapsed;
			monitor_status_t st;
			if (kind == KIND_REPORT) begin
				// short reports are dropped whole; zero voltage keeps only the flags
				if (nbytes >= MIN_REPORT_BYTES) begin
					flags = fl;
					if (v != 16'd0) begin
						batt_mv = v;
						if (v > peak_mv)
							peak_mv = v;
						if (floor_mv == 16'd0 || v < floor_mv)
							floor_mv = v;
					end
				end
			end else begin
				thr = fly ? thr_flying_mv : thr_static_mv;
				// low voltage: stamp once, then time out into low power
				if (batt_mv < thr) begin
					elapsed = now - low_since_ms;
					if (low_since_ms == 32'd0)
						low_since_ms = now;
					else if (elapsed > {16'd0, timeout_ms})
						state = ST_LOW_POWER;
				end else begin
					low_since_ms = '0;
					if (state == ST_LOW_POWER)
						state = ST_BATTERY;
				end
				// charger flags take priority
				if (flags[FLAG_PGOOD_BIT] && !flags[FLAG_CHG_BIT])
					state = ST_CHARGED;
				else if (flags[FLAG_PGOOD_BIT] && flags[FLAG_CHG_BIT])
					state = ST_CHARGING;
				else if (state != ST_LOW_POWER)
					state = ST_BATTERY;
			end
			st.voltage_now_mv   = batt_mv;
			st.voltage_peak_mv  = peak_mv;
			st.voltage_floor_mv = floor_mv;
			st.power_state      = state;
			st.is_low_power     = (state == ST_LOW_POWER);
			st.is_charging      = (state == ST_CHARGING);
			st.monitor_ok       = (batt_mv != 16'd0);
			status_q.push_back(st);
		endfunction

		// compare one status item from the block with the oldest one owed
		function void check_status(monitor_status_t got);
			monitor_status_t want;
			if (status_q.size() == 0) begin
				$error("status item with nothing owed: voltage_now_mv %0d power_state %0d",
					got.voltage_now_mv, got.power_state);
				fail_count++;
				return;
			end
			want = status_q.pop_front();
			if (got.voltage_now_mv !== want.voltage_now_mv) begin
				$error("voltage_now_mv: expected %0d, got %0d",
					want.voltage_now_mv, got.voltage_now_mv);
				fail_count++;
			end
			if (got.voltage_peak_mv !== want.voltage_peak_mv) begin
				$error("voltage_peak_mv: expected %0d, got %0d",
					want.voltage_peak_mv, got.voltage_peak_mv);
				fail_count++;
			end
			if (got.voltage_floor_mv !== want.voltage_floor_mv) begin
				$error("voltage_floor_mv: expected %0d, got %0d",
					want.voltage_floor_mv, got.voltage_floor_mv);
				fail_count++;
			end
			if (got.power_state !== want.power_state) begin
				$error("power_state: expected %0d, got %0d",
					want.power_state, got.power_state);
				fail_count++;
			end
			if (got.is_low_power !== want.is_low_power) begin
				$error("is_low_power: expected %0d, got %0d",
					want.is_low_power, got.is_low_power);
				fail_count++;
			end
			if (got.is_charging !== want.is_charging) begin
				$error("is_charging: expected %0d, got %0d",
					want.is_charging, got.is_charging);
				fail_count++;
			end
			if (got.monitor_ok !== want.monitor_ok) begin
				$error("monitor_ok: expected %0d, got %0d",
					want.monitor_ok, got.monitor_ok);
				fail_count++;
			end
		endfunction
	endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: drives reports, ticks and threshold writes into the battery monitor and checks
// every status item; depends on bpsm_pkg, bpsm_status_pkg and the monitor RTL

module tb_top;
	import bpsm_pkg::*;
	import bpsm_status_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = KIND_REPORT;
	logic [7:0]  report_bytes = '0;
	logic [15:0] voltage_mv = '0;
	logic [1:0]  charger_flags = '0;
	logic        flying = 1'b0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_ready = 1'b1;
	logic [15:0] voltage_now_mv;
	logic [15:0] voltage_peak_mv;
	logic [15:0] voltage_floor_mv;
	logic [1:0]  power_state;
	logic        is_low_power;
	logic        is_charging;
	logic        monitor_ok;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_index_t  cfg_index = CFG_THR_FLYING;
	logic [15:0] cfg_data = '0;

	monitor_status_board board;
	logic        tx_quiet = 1'b0;
	logic        rx_quiet = 1'b0;
	int          statuses_seen = 0;
	int          quiet_cycles = 0;
	logic [31:0] clock_ms = '0;

	battery_power_state_monitor DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.report_bytes     (report_bytes),
		.voltage_mv       (voltage_mv),
		.charger_flags    (charger_flags),
		.flying           (flying),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.voltage_now_mv   (voltage_now_mv),
		.voltage_peak_mv  (voltage_peak_mv),
		.voltage_floor_mv (voltage_floor_mv),
		.power_state      (power_state),
		.is_low_power     (is_low_power),
		.is_charging      (is_charging),
		.monitor_ok       (monitor_ok),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// offer one item after a random gap; valid stays up when the next follows at once
	task automatic send_item(input logic k, input logic [7:0] nb, input logic [15:0] v,
		input logic [1:0] fl, input logic fly, input logic [31:0] now);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= k;
		report_bytes  <= nb;
		voltage_mv    <= v;
		charger_flags <= fl;
		flying        <= fly;
		now_ms        <= now;
		do @(posedge clk); while (!in_ready);
		board.note_item(k, nb, v, fl, fly, now);
	endtask

	// tick and report fields that do not apply to the kind are left random
	task automatic send_report(input logic [7:0] nb, input logic [15:0] v, input logic [1:0] fl);
		send_item(KIND_REPORT, nb, v, fl, 1'($urandom_range(0, 1)), $urandom());
	endtask

	task automatic send_tick(input logic fly, input logic [31:0] now);
		send_item(KIND_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			2'($urandom_range(0, 3)), fly, now);
	endtask

	// mostly voltages around the live thresholds and time moving forward
	task automatic send_random_item();
		int pick;
		int vtmp;
		int tmo;
		logic [7:0] nb;
		logic [15:0] v;
		logic [1:0] fl;
		logic [31:0] now;
		pick = $urandom_range(0, 99);
		tmo = board.timeout_ms;
		if ($urandom_range(0, 99) < 55) begin
			if (pick < 4) begin
				now = $urandom();
			end else if (pick < 8) begin
				clock_ms = '0;
				now = clock_ms;
			end else if (pick < 11) begin
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * tmo + 100);
				now = clock_ms;
			end else begin
				clock_ms = clock_ms + $urandom_range(0, tmo / 2 + 20);
				now = clock_ms;
			end
			send_tick(1'($urandom_range(0, 1)), now);
		end else begin
			if (pick < 8)
				nb = 8'($urandom_range(0, 4));
			else if (pick < 12)
				nb = 8'd255;
			else if (pick < 20)
				nb = 8'($urandom_range(0, 255));
			else
				nb = 8'($urandom_range(5, 40));
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				v = '0;
			end else if (pick < 18) begin
				v = 16'($urandom_range(0, 65535));
			end else if (pick < 22) begin
				v = 16'hFFFF;
			end else begin
				vtmp = $urandom_range(0, 1) ? int'(board.thr_flying_mv) : int'(board.thr_static_mv);
				vtmp = vtmp + int'($urandom_range(0, 300)) - 150;
				if (vtmp < 0)
					vtmp = 0;
				if (vtmp > 65535)
					vtmp = 65535;
				v = 16'(vtmp);
			end
			fl = ($urandom_range(0, 99) < 65) ? 2'd0 : 2'($urandom_range(0, 3));
			send_report(nb, v, fl);
		end
	endtask

	// drop valid and wait until every owed status has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	// write all three registers back to back
	task automatic program_regs(input logic [15:0] fly_thr, input logic [15:0] static_thr,
		input logic [15:0] tmo);
		cfg_index_t order[3] = '{CFG_THR_FLYING, CFG_THR_STATIC, CFG_TIMEOUT};
		logic [15:0] vals[3];
		vals[0] = fly_thr;
		vals[1] = static_thr;
		vals[2] = tmo;
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			board.write_reg(order[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] fly_thr, input logic [15:0] static_thr,
		input logic [15:0] tmo, input int count, input logic [1:0] idle_mode);
		drain();
		program_regs(fly_thr, static_thr, tmo);
		tx_quiet = idle_mode[0];
		rx_quiet = idle_mode[1];
		repeat (count) send_random_item();
	endtask

	// result side: random stalls, plus two long hold-offs to back up the input
	initial begin
		int stall;
		monitor_status_t got;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (statuses_seen == 300 || statuses_seen == 800)
				stall = HOLD_CYCLES;
			else
				stall = rx_quiet ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end
			do @(posedge clk); while (!out_valid);
			got.voltage_now_mv   = voltage_now_mv;
			got.voltage_peak_mv  = voltage_peak_mv;
			got.voltage_floor_mv = voltage_floor_mv;
			got.power_state      = power_state_t'(power_state);
			got.is_low_power     = is_low_power;
			got.is_charging      = is_charging;
			got.monitor_ok       = monitor_ok;
			board.check_status(got);
			statuses_seen++;
		end
	end

	// watchdog on cycles where no channel moves anything
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset thresholds, short and zero-voltage reports, flag overrides
		send_tick(1'b0, 32'd100);
		send_report(8'd4, 16'd1234, 2'd3);
		send_report(8'd0, 16'hFFFF, 2'd1);
		send_report(8'd5, 16'd0, 2'd1);
		send_tick(1'b1, 32'd200);
		send_report(8'd255, 16'hFFFF, 2'd3);
		send_tick(1'b0, 32'd300);
		send_report(8'd5, 16'd1, 2'd0);
		send_report(8'd6, 16'd1000, 2'd0);
		// stamp at time zero does not count, then timeout boundary
		send_tick(1'b0, 32'd0);
		send_tick(1'b0, 32'd10);
		send_tick(1'b1, 32'd5010);
		send_tick(1'b1, 32'd5011);
		send_report(8'd5, 16'd0, 2'd2);
		send_tick(1'b0, 32'd6000);
		// between thresholds: low while flying, recovered on the ground
		send_report(8'd5, 16'd3100, 2'd0);
		send_tick(1'b1, 32'd7000);
		send_tick(1'b0, 32'd7100);
		// low time across the 32-bit wrap
		send_report(8'd5, 16'd500, 2'd0);
		send_tick(1'b0, 32'hFFFF_FF00);
		send_tick(1'b0, 32'h0000_1000);
		send_tick(1'b1, 32'h0000_1389);
		send_report(8'd200, 16'd500, 2'd1);
		send_tick(1'b0, 32'h0000_2000);
		send_report(8'd5, 16'd0, 2'd3);
		send_tick(1'b1, 32'hFFFF_FFFF);

		// random items under the reset thresholds, then a series of register settings
		repeat (200) send_random_item();
		run_phase(16'd0, 16'd0, 16'd0, 140, 2'd1);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 140, 2'd0);
		run_phase(16'd3300, 16'd3100, 16'd0, 140, 2'd2);
		run_phase(16'hFFFF, 16'd0, 16'd1, 140, 2'd3);
		run_phase(16'($urandom_range(2500, 4500)), 16'($urandom_range(2500, 4500)),
			16'($urandom_range(0, 2000)), 140, 2'd0);
		run_phase(16'd3200, 16'd3000, 16'd5000, 140, 2'd1);
		run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 140, 2'd0);

		drain();
		repeat (4) @(posedge clk);
		if (board.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
